@@ sv/kcc_pkg.sv @@
package kcc_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned KeyW   = 3;
  localparam int unsigned CodeW  = 5;
  localparam int unsigned TicksW = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  localparam int unsigned QueueDepthDefault = 16;

  // Item operation codes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_LONG_PRESS = 1'b0;
  localparam logic REG_DOUBLE_GAP = 1'b1;

  localparam logic [TicksW-1:0] LONG_PRESS_RESET = 16'd80;
  localparam logic [TicksW-1:0] DOUBLE_GAP_RESET = 16'd25;

  localparam logic [CodeW-1:0] LONG_OFFSET   = 5'd10;
  localparam logic [CodeW-1:0] DOUBLE_OFFSET = 5'd20;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_DEBOUNCE    = 3'd1,
    PH_HELD        = 3'd2,
    PH_LONG_HELD   = 3'd3,
    PH_GAP         = 3'd4,
    PH_SECOND      = 3'd5,
    PH_DOUBLE_HELD = 3'd6
  } phase_e;

  // Event handed from the classifier to the queue.
  typedef struct packed {
    logic             valid;
    logic [CodeW-1:0] code;
  } push_t;

endpackage

@@ sv/kcc_classifier.sv @@
module kcc_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tick_en_i,
  input  logic [kcc_pkg::KeyW-1:0]   key_i,
  input  logic [kcc_pkg::TicksW-1:0] long_press_ticks_i,
  input  logic [kcc_pkg::TicksW-1:0] double_gap_ticks_i,
  output kcc_pkg::push_t             push_o
);
  import kcc_pkg::*;

  phase_e            phase_q, phase_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic [TicksW-1:0] ticks_inc;
  logic [CodeW-1:0]  key_code;

  assign ticks_inc = ticks_q + 16'd1;
  assign key_code  = {2'b00, key_q};

  // Next state.
  always_comb begin
    phase_d = phase_q;
    key_d   = key_q;
    ticks_d = ticks_q;
    if (tick_en_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (key_i != '0) begin
            key_d   = key_i;
            phase_d = PH_DEBOUNCE;
          end
        end
        PH_DEBOUNCE: begin
          if (key_i == key_q) begin
            phase_d = PH_HELD;
            ticks_d = '0;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        PH_HELD: begin
          if (key_i == key_q) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= long_press_ticks_i) begin
              phase_d = PH_LONG_HELD;
            end
          end else if (key_i == '0) begin
            ticks_d = '0;
            phase_d = PH_GAP;
          end else begin
            key_d   = key_i;
            phase_d = PH_DEBOUNCE;
          end
        end
        PH_LONG_HELD, PH_DOUBLE_HELD: begin
          if (key_i == '0) begin
            phase_d = PH_IDLE;
          end
        end
        PH_GAP: begin
          if (key_i == '0) begin
            ticks_d = ticks_inc;
            if (ticks_inc >= double_gap_ticks_i) begin
              phase_d = PH_IDLE;
            end
          end else if (key_i == key_q) begin
            phase_d = PH_SECOND;
          end else begin
            key_d   = key_i;
            phase_d = PH_DEBOUNCE;
          end
        end
        PH_SECOND: begin
          if (key_i == key_q) begin
            phase_d = PH_DOUBLE_HELD;
          end else begin
            phase_d = PH_GAP;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Event output.
  always_comb begin
    push_o.valid = 1'b0;
    push_o.code  = key_code;
    if (tick_en_i) begin
      unique case (phase_q)
        PH_HELD: begin
          if (key_i == key_q) begin
            if (ticks_inc >= long_press_ticks_i) begin
              push_o.valid = 1'b1;
              push_o.code  = key_code + LONG_OFFSET;
            end
          end else if (key_i != '0) begin
            push_o.valid = 1'b1;
          end
        end
        PH_GAP: begin
          if (key_i == '0) begin
            push_o.valid = (ticks_inc >= double_gap_ticks_i);
          end else if (key_i != key_q) begin
            push_o.valid = 1'b1;
          end
        end
        PH_SECOND: begin
          if (key_i == key_q) begin
            push_o.valid = 1'b1;
            push_o.code  = key_code + DOUBLE_OFFSET;
          end
        end
        default: begin
          push_o.valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      key_q   <= '0;
      ticks_q <= '0;
    end else begin
      phase_q <= phase_d;
      key_q   <= key_d;
      ticks_q <= ticks_d;
    end
  end

  // Events come only out of a held, gap or second-press phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> (phase_q == PH_HELD || phase_q == PH_GAP || phase_q == PH_SECOND))
    else $error("event pushed from an unexpected phase");

endmodule

@@ sv/kcc_event_queue.sv @@
module kcc_event_queue #(
  parameter int unsigned QueueDepth = kcc_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kcc_pkg::push_t            push_i,
  input  logic                      load_i,
  input  logic                      read_en_i,
  output logic                      event_valid_o,
  output logic [kcc_pkg::CodeW-1:0] event_code_o
);
  import kcc_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QueueDepth - 1);

  logic [CodeW-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW-1:0]  wr_next, rd_next;
  logic             full, empty, do_push, do_pop;
  logic             valid_q;
  logic [CodeW-1:0] code_q;

  assign wr_next = (wr_q == LastSlot) ? '0 : wr_q + PtrW'(1);
  assign rd_next = (rd_q == LastSlot) ? '0 : rd_q + PtrW'(1);
  assign full    = (wr_next == rd_q);
  assign empty   = (wr_q == rd_q);
  // One slot always stays free, so a full queue drops the new event.
  assign do_push = push_i.valid && !full;
  assign do_pop  = load_i && read_en_i && !empty;
  assign wr_d    = do_push ? wr_next : wr_q;
  assign rd_d    = do_pop ? rd_next : rd_q;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.code;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      if (do_pop) begin
        code_q <= mem_q[rd_q];
      end else begin
        code_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      if (load_i) begin
        valid_q <= do_pop;
      end
    end
  end

  assign event_valid_o = valid_q;
  assign event_code_o  = code_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push |=> (wr_q != rd_q))
    else $error("queue looks empty right after a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && read_en_i && empty) |=> (!event_valid_o && $stable(rd_q)))
    else $error("read of an empty queue returned an event");

endmodule

@@ sv/key_click_classifier_with_event_fifo_unit.sv @@
// Key click classifier with event queue. Every input item is either a tick carrying the
// pressed key code (0 none, 1 to 7) or a read. Ticks drive a debounce/long/double-click
// state machine that pushes short (k), long (k+10) or double (k+20) events into a ring
// queue of QueueDepth slots with one slot kept free; a new event is dropped when it is
// full. Every item gives exactly one result: a read returns the oldest event with
// event_valid 1, or valid 0 and code 0 when the queue is empty; a tick returns zeros.
// One item is accepted per cycle while in_stall_o is low; each item is held in the input
// register and its result is then loaded into the output register.
// Registers: long_press_ticks at address 0 (reset 80), double_gap_ticks at 4 (reset 25).
module key_click_classifier_with_event_fifo_unit #(
  parameter int unsigned QueueDepth = kcc_pkg::QueueDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      operation_i,
  input  logic [kcc_pkg::KeyW-1:0]  key_sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      event_valid_o,
  output logic [kcc_pkg::CodeW-1:0] event_code_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [kcc_pkg::AddrW-1:0] paddr,
  input  logic [kcc_pkg::DataW-1:0] pwdata,
  output logic [kcc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import kcc_pkg::*;

  logic              in_valid_q;
  logic              op_q;
  logic [KeyW-1:0]   key_q;
  logic              out_valid_q;
  logic              advance;
  logic              accept;
  logic [TicksW-1:0] long_press_q;
  logic [TicksW-1:0] double_gap_q;
  logic              cfg_write;
  push_t             push;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[2])
      REG_LONG_PRESS: prdata = {16'd0, long_press_q};
      REG_DOUBLE_GAP: prdata = {16'd0, double_gap_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
      double_gap_q <= DOUBLE_GAP_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_LONG_PRESS) begin
        long_press_q <= pwdata[TicksW-1:0];
      end else begin
        double_gap_q <= pwdata[TicksW-1:0];
      end
    end
  end

  // The item in the input register moves on whenever the result register is free
  // or being emptied in the same cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= key_sample_i;
    end
  end

  kcc_classifier u_classifier (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .tick_en_i          (advance && (op_q == OP_TICK)),
    .key_i              (key_q),
    .long_press_ticks_i (long_press_q),
    .double_gap_ticks_i (double_gap_q),
    .push_o             (push)
  );

  kcc_event_queue #(
    .QueueDepth (QueueDepth)
  ) u_event_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .load_i        (advance),
    .read_en_i     (op_q == OP_READ),
    .event_valid_o (event_valid_o),
    .event_code_o  (event_code_o)
  );

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_valid_q) |-> !in_stall_o)
    else $error("input stalled while the result register is empty");

endmodule
